### rtl/euler_graph_classifier_macros.svh
// ============================================================================
// euler_graph_classifier_macros.svh
// Assertion macros shared by the classifier's checker.
// ============================================================================
`ifndef EULER_GRAPH_CLASSIFIER_MACROS_SVH
`define EULER_GRAPH_CLASSIFIER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define EGC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("euler_graph_classifier: assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define EGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("euler_graph_classifier: assertion failed");

`endif

### rtl/egc_pkg.sv
// ============================================================================
// egc_pkg
// Field widths, request and class codes, controller/datapath bundles.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package egc_pkg;

    // Payload field widths
    localparam int REQ_W = 2;
    localparam int VTX_W = 6;
    localparam int CNT_W = 7;
    localparam int CLS_W = 2;
    localparam int ODD_W = 7;

    // Reset value of the vertex count register
    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Result classes
    localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
    localparam logic [CLS_W-1:0] CLS_PATH    = 2'd1;
    localparam logic [CLS_W-1:0] CLS_CIRCUIT = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic add_a;      // write row of endpoint a
        logic add_b;      // write row of endpoint b
        logic clear;      // empty the graph
        logic walk_init;  // seed walk, reset odd counter
        logic pick;       // take lowest pending vertex, read its row
        logic merge;      // fold row into reached/pending sets
        logic cnt_step;   // count one parity bit
        logic finish;     // load result when output is free
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic pend_any;
        logic cnt_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/egc_if.sv
// ============================================================================
// egc_if
// Valid/ready channel interfaces: request, result and config write.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface egc_req_if;
    import egc_pkg::*;

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;

    modport source (output valid, output req_type, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input req_type, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface egc_res_if;
    import egc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] euler_class;
    logic             all_connected;
    logic [ODD_W-1:0] odd_vertices;

    modport source (output valid, output euler_class, output all_connected,
                    output odd_vertices, input ready);
    modport sink   (input valid, input euler_class, input all_connected,
                    input odd_vertices, output ready);
endinterface

interface egc_cfg_if;
    import egc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/egc_ctrl.sv
// ============================================================================
// egc_ctrl
// Request sequencer: edge writes, clear, reachability walk, odd count, result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module egc_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic [egc_pkg::REQ_W-1:0] i_req_type,
    input  wire egc_pkg::t_sts           i_sts,
    output egc_pkg::t_cmd                o_cmd,
    output logic                         o_ready
);
    import egc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_CLEAR,
        S_INIT,
        S_PICK,
        S_MERGE,
        S_COUNT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd,   n_cmd;
    logic   r_ready, n_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_ADD_B: begin
                n_state = S_IDLE;
                if (i_accept) begin
                    unique case (i_req_type)
                        REQ_ADD:   n_state = S_ADD_A;
                        REQ_CHECK: n_state = S_INIT;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_A: n_state = S_ADD_B;
            S_CLEAR: n_state = S_IDLE;
            S_INIT:  n_state = S_PICK;
            S_PICK:  n_state = i_sts.pend_any ? S_MERGE : S_COUNT;
            S_MERGE: n_state = S_PICK;
            S_COUNT: n_state = i_sts.cnt_last ? S_DONE : S_COUNT;
            S_DONE:  n_state = i_sts.out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Commands follow the state being entered
    always_comb begin
        n_cmd           = '0;
        n_cmd.add_a     = (n_state == S_ADD_A);
        n_cmd.add_b     = (n_state == S_ADD_B);
        n_cmd.clear     = (n_state == S_CLEAR);
        n_cmd.walk_init = (n_state == S_INIT);
        n_cmd.pick      = (n_state == S_PICK);
        n_cmd.merge     = (n_state == S_MERGE);
        n_cmd.cnt_step  = (n_state == S_COUNT);
        n_cmd.finish    = (n_state == S_DONE);
        n_ready         = (n_state == S_IDLE) || (n_state == S_ADD_B);
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cmd   <= '0;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cmd   <= n_cmd;
            r_ready <= n_ready;
        end
    end

    assign o_cmd   = r_cmd;
    assign o_ready = r_ready;

endmodule

`default_nettype wire

### rtl/egc_dpath.sv
// ============================================================================
// egc_dpath
// Adjacency row memory, vertex bit sets, walk and odd-count datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module egc_dpath #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire egc_pkg::t_cmd             i_cmd,
    output egc_pkg::t_sts                  o_sts,
    // request payload, latched on transfer
    input  wire logic                      i_load,
    input  wire logic [egc_pkg::VTX_W-1:0] i_vertex_a,
    input  wire logic [egc_pkg::VTX_W-1:0] i_vertex_b,
    // config write
    input  wire logic                      i_cfg_we,
    input  wire logic [egc_pkg::CNT_W-1:0] i_cfg_data,
    // result register
    input  wire logic                      i_res_ready,
    output logic                           o_res_valid,
    output logic [egc_pkg::CLS_W-1:0]      o_euler_class,
    output logic                           o_all_connected,
    output logic [egc_pkg::ODD_W-1:0]      o_odd_vertices
);
    import egc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int MW = (CW > CNT_W) ? CW : CNT_W;

    typedef logic [MAX_VERTICES-1:0] t_set;

    // Storage
    t_set             r_adj [MAX_VERTICES];
    t_set             r_has_edge;
    t_set             r_parity;
    t_set             r_reach;
    t_set             r_pend;
    t_set             r_row_q;
    logic             r_row_ok;
    logic [CNT_W-1:0] r_vertex_count;
    logic [VTX_W-1:0] r_va;
    logic [VTX_W-1:0] r_vb;
    logic [VW-1:0]    r_idx;
    logic [CW-1:0]    r_odd;
    logic             r_out_valid;
    logic [CLS_W-1:0] r_class;
    logic             r_conn;
    logic [ODD_W-1:0] r_odd_out;

    logic [MW-1:0] cfg_ext;
    logic [CW-1:0] n_act;
    t_set          inuse;
    logic          edge_ok;
    logic          wr_en;
    logic [VW-1:0] wr_row;
    logic [VW-1:0] wr_col;
    t_set          hv;
    t_set          start_set;
    t_set          low;
    logic [VW-1:0] pick_idx;
    t_set          new_set;
    logic          conn;
    logic          out_free;
    logic          res_load;
    logic [CLS_W-1:0] cls;

    // Effective vertex count: zero acts as one, clamp at capacity
    always_comb begin
        cfg_ext = MW'(r_vertex_count);
        if (cfg_ext == '0)
            n_act = CW'(1);
        else if (cfg_ext > MW'(MAX_VERTICES))
            n_act = CW'(MAX_VERTICES);
        else
            n_act = CW'(cfg_ext);
    end

    // Vertices below the count
    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++)
            inuse[v] = (MW'(v) < MW'(n_act));
    end

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_vertex_count <= VCOUNT_RESET;
        else if (i_cfg_we)
            r_vertex_count <= i_cfg_data;
    end

    // Edge endpoints
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_va <= i_vertex_a;
            r_vb <= i_vertex_b;
        end
    end

    assign edge_ok = (MW'(r_va) < MW'(n_act)) && (MW'(r_vb) < MW'(n_act));
    assign wr_en   = (i_cmd.add_a || i_cmd.add_b) && edge_ok;
    assign wr_row  = i_cmd.add_a ? VW'(r_va) : VW'(r_vb);
    assign wr_col  = i_cmd.add_a ? VW'(r_vb) : VW'(r_va);

    // Walk seed: lowest in-use vertex with an edge
    assign hv        = r_has_edge & inuse;
    assign start_set = hv & (~hv + t_set'(1));

    // Lowest pending vertex, one-hot and encoded
    assign low = r_pend & (~r_pend + t_set'(1));
    always_comb begin
        pick_idx = '0;
        for (int v = 0; v < MAX_VERTICES; v++)
            if (low[v])
                pick_idx = pick_idx | VW'(v);
    end

    // Newly reached neighbors
    assign new_set = (r_row_ok ? r_row_q : '0) & inuse & ~r_reach;

    // Adjacency memory: a row not yet written since clear is rewritten whole
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_has_edge[wr_row])
                r_adj[wr_row][wr_col] <= 1'b1;
            else
                r_adj[wr_row] <= t_set'(1) << wr_col;
        end
        if (i_cmd.pick)
            r_row_q <= r_adj[pick_idx];
    end

    // Row-valid (has-edge) and degree parity, one row per write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_edge <= '0;
            r_parity   <= '0;
        end else if (i_cmd.clear) begin
            r_has_edge <= '0;
            r_parity   <= '0;
        end else if (wr_en) begin
            r_has_edge[wr_row] <= 1'b1;
            r_parity[wr_row]   <= ~r_parity[wr_row];
        end
    end

    // Reached and pending sets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach  <= '0;
            r_pend   <= '0;
            r_row_ok <= 1'b0;
        end else if (i_cmd.walk_init) begin
            r_reach  <= start_set;
            r_pend   <= start_set;
        end else if (i_cmd.pick) begin
            r_pend   <= r_pend & ~low;
            r_row_ok <= r_has_edge[pick_idx];
        end else if (i_cmd.merge) begin
            r_reach  <= r_reach | new_set;
            r_pend   <= r_pend | new_set;
        end
    end

    // Odd-degree count, one vertex per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_idx <= '0;
            r_odd <= '0;
        end else if (i_cmd.cnt_step) begin
            r_idx <= r_idx + VW'(1);
            r_odd <= r_odd + CW'(r_parity[r_idx]);
        end
    end

    // Classification
    assign conn = ~|(r_has_edge & inuse & ~r_reach);
    always_comb begin
        if (!conn || (r_odd > CW'(2)))
            cls = CLS_NONE;
        else if (r_odd == '0)
            cls = CLS_CIRCUIT;
        else
            cls = CLS_PATH;
    end

    // Output register
    assign out_free = !r_out_valid || i_res_ready;
    assign res_load = i_cmd.finish && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (res_load)
            r_out_valid <= 1'b1;
        else if (i_res_ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_class   <= cls;
            r_conn    <= conn;
            r_odd_out <= ODD_W'(r_odd);
        end
    end

    // Status
    assign o_sts.pend_any = |r_pend;
    assign o_sts.cnt_last = (CW'(r_idx) == (n_act - CW'(1)));
    assign o_sts.out_free = out_free;

    assign o_res_valid     = r_out_valid;
    assign o_euler_class   = r_class;
    assign o_all_connected = r_conn;
    assign o_odd_vertices  = r_odd_out;

endmodule

`default_nettype wire

### rtl/euler_graph_classifier.sv
// ============================================================================
// euler_graph_classifier
// Euler path/circuit classifier for an undirected multigraph loaded by edge.
// ============================================================================
// An add-edge request writes the two adjacency rows in turn (ADD_A, then
// ADD_B) through the single write port of the row memory, and the next
// request is taken in ADD_B. A clear drops the per-row valid bits, so no
// memory sweep follows reset or clear. A check first walks the graph from
// the lowest in-use vertex with an edge: the walk reads one adjacency row
// per pick and merge pair (pick, then merge of the registered read data),
// and the odd degree count then looks at one parity bit per cycle over the
// effective vertex count. A finished result sits in an output register;
// edge and clear requests are still taken while it waits, and a further
// check runs but holds its result in the done state until the waiting one is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module euler_graph_classifier #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    egc_req_if.sink    i_req,
    egc_res_if.source  o_res,
    egc_cfg_if.sink    i_cfg
);
    import egc_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;
    logic accept;

    assign i_req.ready = req_ready;
    assign accept      = i_req.valid && req_ready;
    assign i_cfg.ready = 1'b1;

    // Sequencer
    egc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (req_ready)
    );

    // Graph store and walk datapath
    egc_dpath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_load          (accept),
        .i_vertex_a      (i_req.vertex_a),
        .i_vertex_b      (i_req.vertex_b),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_res_ready     (o_res.ready),
        .o_res_valid     (o_res.valid),
        .o_euler_class   (o_res.euler_class),
        .o_all_connected (o_res.all_connected),
        .o_odd_vertices  (o_res.odd_vertices)
    );

endmodule

`default_nettype wire

### rtl/egc_checker.sv
// ============================================================================
// egc_checker
// Port-level checks on the classifier, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "euler_graph_classifier_macros.svh"

module egc_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      req_valid,
    input wire logic                      req_ready,
    input wire logic [egc_pkg::REQ_W-1:0] req_type,
    input wire logic                      res_valid,
    input wire logic                      res_ready,
    input wire logic [egc_pkg::CLS_W-1:0] euler_class,
    input wire logic                      all_connected,
    input wire logic [egc_pkg::ODD_W-1:0] odd_vertices
);
    import egc_pkg::*;

    logic circuit_ok;

    // Connected and no odd vertex
    assign circuit_ok = all_connected && (odd_vertices == '0);

    // A stalled result stays offered
    `EGC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

    // A split graph is never Eulerian
    `EGC_ASSERT_IMPL(a_split_none, res_valid && !all_connected, euler_class == CLS_NONE)

    // A circuit needs a connected graph with no odd vertex
    `EGC_ASSERT_IMPL(a_circuit_even, res_valid && euler_class == CLS_CIRCUIT, circuit_ok)

    // A check transfer starts the walk, so no request is taken next cycle
    `EGC_ASSERT_NEXT(a_check_busy, req_valid && req_ready && req_type == REQ_CHECK, !req_ready)

endmodule

bind euler_graph_classifier egc_checker u_egc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .req_valid     (i_req.valid),
    .req_ready     (i_req.ready),
    .req_type      (i_req.req_type),
    .res_valid     (o_res.valid),
    .res_ready     (o_res.ready),
    .euler_class   (o_res.euler_class),
    .all_connected (o_res.all_connected),
    .odd_vertices  (o_res.odd_vertices)
);

`default_nettype wire
